[hdl/xdet_pkg.sv]
package xdet_pkg;

	typedef logic [7:0] byte_t;

	localparam byte_t CH_NUL   = 8'h00;
	localparam byte_t CH_NL    = 8'h0A;
	localparam byte_t CH_LT    = 8'h3C;
	localparam byte_t CH_GT    = 8'h3E;
	localparam byte_t CH_SLASH = 8'h2F;

	localparam int CD_BEGIN_LEN = 9;
	localparam int CD_END_LEN   = 3;
	localparam int CM_BEGIN_LEN = 4;
	localparam int CM_END_LEN   = 3;

	// "<![CDATA[" and "]]>"
	localparam byte_t CD_BEGIN [CD_BEGIN_LEN] = '{
		8'h3C, 8'h21, 8'h5B, 8'h43, 8'h44, 8'h41, 8'h54, 8'h41, 8'h5B
	};
	localparam byte_t CD_END [CD_END_LEN] = '{8'h5D, 8'h5D, 8'h3E};
	// "<!--" and "-->"
	localparam byte_t CM_BEGIN [CM_BEGIN_LEN] = '{8'h3C, 8'h21, 8'h2D, 8'h2D};
	localparam byte_t CM_END [CM_END_LEN] = '{8'h2D, 8'h2D, 8'h3E};

	typedef struct packed {
		logic       first_pending;
		logic       xml_mode;
		logic [3:0] cd_pos;
		logic [1:0] cm_pos;
		logic       in_cdata;
		logic       in_comment;
		logic       inside_tag;
		logic       tag_first;
		logic       closing_tag;
		logic       special_tag;
		byte_t      prev_byte;
		logic       done;
		logic       saturated;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		first_pending: 1'b1,
		xml_mode:      1'b0,
		cd_pos:        4'd0,
		cm_pos:        2'd0,
		in_cdata:      1'b0,
		in_comment:    1'b0,
		inside_tag:    1'b0,
		tag_first:     1'b0,
		closing_tag:   1'b0,
		special_tag:   1'b0,
		prev_byte:     8'h00,
		done:          1'b0,
		saturated:     1'b0
	};

endpackage

[hdl/xdet_step.sv]
module xdet_step #(
	parameter int COUNT_BITS = 16
) (
	input  xdet_pkg::scan_state_t   st,
	input  logic [COUNT_BITS-1:0]   cnt,
	input  xdet_pkg::byte_t         data_byte,
	output xdet_pkg::scan_state_t   nxt,
	output logic [COUNT_BITS-1:0]   nxt_cnt
);

	logic       cd_hit;
	logic       cm_hit;
	logic       cd_match;
	logic       cm_match;
	logic [3:0] cdp;
	logic [1:0] cmp;
	logic [1:0] endp;
	logic       is_letter;

	always_comb begin
		nxt      = st;
		nxt_cnt  = cnt;
		cd_hit   = 1'b0;
		cm_hit   = 1'b0;
		cd_match = 1'b0;
		cm_match = 1'b0;
		cdp      = (st.cd_pos < 4'(xdet_pkg::CD_BEGIN_LEN)) ? st.cd_pos : 4'd0;
		cmp      = st.cm_pos;
		endp     = 2'd0;
		is_letter = (data_byte >= 8'h41 && data_byte <= 8'h5A) ||
			(data_byte >= 8'h61 && data_byte <= 8'h7A);

		if (!st.done) begin
			nxt.first_pending = 1'b0;
			if (st.first_pending) begin
				nxt.xml_mode = (data_byte == xdet_pkg::CH_LT);
			end

			if (data_byte != xdet_pkg::CH_NUL) begin
				if (st.in_cdata) begin
					endp = (st.cd_pos < 4'(xdet_pkg::CD_END_LEN)) ? st.cd_pos[1:0] : 2'd0;
					if (data_byte == xdet_pkg::CD_END[endp]) begin
						if (endp == 2'(xdet_pkg::CD_END_LEN - 1)) begin
							nxt.cd_pos   = 4'd0;
							nxt.in_cdata = 1'b0;
						end else begin
							nxt.cd_pos = 4'(endp) + 4'd1;
						end
					end else begin
						nxt.cd_pos = 4'd0;
					end
				end else if (st.in_comment) begin
					endp = (st.cm_pos < 2'(xdet_pkg::CM_END_LEN)) ? st.cm_pos : 2'd0;
					if (data_byte == xdet_pkg::CM_END[endp]) begin
						if (endp == 2'(xdet_pkg::CM_END_LEN - 1)) begin
							nxt.cm_pos     = 2'd0;
							nxt.in_comment = 1'b0;
						end else begin
							nxt.cm_pos = endp + 2'd1;
						end
					end else begin
						nxt.cm_pos = 2'd0;
					end
				end else begin
					cd_match = (data_byte == xdet_pkg::CD_BEGIN[cdp]);
					cm_match = (data_byte == xdet_pkg::CM_BEGIN[cmp]);
					cd_hit   = cd_match && (cdp == 4'(xdet_pkg::CD_BEGIN_LEN - 1));
					cm_hit   = cm_match && (cmp == 2'(xdet_pkg::CM_BEGIN_LEN - 1));

					if (cd_hit) begin
						nxt.cd_pos   = 4'd0;
						nxt.in_cdata = 1'b1;
					end else if (cd_match) begin
						nxt.cd_pos = cdp + 4'd1;
					end else begin
						nxt.cd_pos = (data_byte == xdet_pkg::CH_LT) ? 4'd1 : 4'd0;
					end

					if (cm_hit) begin
						nxt.cm_pos     = 2'd0;
						nxt.in_comment = 1'b1;
					end else if (cm_match) begin
						nxt.cm_pos = cmp + 2'd1;
					end else begin
						nxt.cm_pos = (data_byte == xdet_pkg::CH_LT) ? 2'd1 : 2'd0;
					end

					if (st.inside_tag) begin
						if (cd_hit || cm_hit) begin
							nxt.inside_tag  = 1'b0;
							nxt.tag_first   = 1'b0;
							nxt.closing_tag = 1'b0;
							nxt.special_tag = 1'b0;
						end else if (st.tag_first) begin
							if (data_byte == xdet_pkg::CH_SLASH) begin
								nxt.closing_tag = 1'b1;
							end else if (!is_letter) begin
								nxt.special_tag = 1'b1;
							end
							nxt.tag_first = 1'b0;
						end else if (data_byte == xdet_pkg::CH_GT) begin
							nxt.inside_tag  = 1'b0;
							nxt.special_tag = 1'b0;
							if (st.closing_tag) begin
								nxt.closing_tag = 1'b0;
								if (cnt != '0) begin
									nxt_cnt = cnt - COUNT_BITS'(1);
									if (cnt == COUNT_BITS'(1)) begin
										nxt.done = 1'b1;
									end
								end
							end else if (!st.special_tag) begin
								if (st.prev_byte != xdet_pkg::CH_SLASH) begin
									if (cnt != '1) begin
										nxt_cnt = cnt + COUNT_BITS'(1);
									end else begin
										nxt.saturated = 1'b1;
									end
								end else if (cnt == '0) begin
									nxt.done = 1'b1;
								end
							end
						end
					end else begin
						if (!nxt.xml_mode && data_byte == xdet_pkg::CH_NL) begin
							nxt.done = 1'b1;
						end else if (cd_hit || cm_hit) begin
							nxt.inside_tag  = 1'b0;
							nxt.tag_first   = 1'b0;
							nxt.closing_tag = 1'b0;
							nxt.special_tag = 1'b0;
						end else if (data_byte == xdet_pkg::CH_LT) begin
							nxt.inside_tag = 1'b1;
							nxt.tag_first  = 1'b1;
						end
					end
				end
			end

			if (!nxt.done) begin
				nxt.prev_byte = data_byte;
			end
		end
	end

endmodule

[hdl/xml_document_end_detector.sv]
// channel | handshake          | payload
// input   | in_valid, in_ready | data_byte
// output  | out_valid,out_ready| doc_complete, nesting_depth, depth_overflow
//
// One byte per cycle sustained while out_ready stays high; a stalled output can delay the result.
// Byte is registered, scan state updates as it moves into the result register.
// arst_n clears all control state and the scan state; no clearing pass.
// A stalled output holds the byte stage; input stalls only when both are full.
module xml_document_end_detector #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        doc_complete,
	output logic [15:0] nesting_depth,
	output logic        depth_overflow
);

	localparam int DEPTH_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;

	logic                  valid_s1;
	xdet_pkg::byte_t       byte_s1;
	logic                  advance;
	xdet_pkg::scan_state_t st_q;
	xdet_pkg::scan_state_t st_nxt;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] cnt_nxt;
	logic                  done_q;
	logic [15:0]           depth_q;
	logic                  ovf_q;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	xdet_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.st        (st_q),
		.cnt       (cnt_q),
		.data_byte (byte_s1),
		.nxt       (st_nxt),
		.nxt_cnt   (cnt_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= xdet_pkg::SCAN_RESET;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (advance) begin
				st_q  <= st_nxt;
				cnt_q <= cnt_nxt;
			end
			if (advance) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			done_q  <= st_nxt.done;
			depth_q <= 16'(cnt_nxt[DEPTH_W-1:0]);
			ovf_q   <= st_nxt.saturated;
		end
	end

	assign doc_complete   = done_q;
	assign nesting_depth  = depth_q;
	assign depth_overflow = ovf_q;

`ifndef SYNTH
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.done |=> st_q.done)
		else $error("completion flag dropped");

	a_frozen_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.done |=> $stable(cnt_q) && $stable(st_q.saturated))
		else $error("state moved after completion");

	a_one_section: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_q.in_cdata && st_q.in_comment))
		else $error("cdata and comment open together");

	a_cd_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.cd_pos < 4'(xdet_pkg::CD_BEGIN_LEN))
		else $error("cdata matcher out of range");
`endif

endmodule
